// File: rtl/gait_event_detector_top_assert.svh
// Assertion shorthands for the gait event detector checker.
// Each macro expects a signal named clk in scope; the two masked ones also expect rst_n.
`ifndef GAIT_EVENT_DETECTOR_TOP_ASSERT_SVH
`define GAIT_EVENT_DETECTOR_TOP_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define GED_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gait event detector: check failed");

// Next-cycle implication, masked during reset.
`define GED_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gait event detector: check failed");

// Next-cycle implication that also watches the reset cycles.
`define GED_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("gait event detector: reset check failed");

`endif

// File: rtl/gaitd_pkg.sv
`default_nettype none

package gaitd_pkg;

  localparam int FORCE_IN_W = 15;
  localparam int GAP_W      = 16;
  localparam int REG_IDX_W  = 3;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_SWING_GAP     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_HEEL_OFF_EN   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_FORE_A_CONTACT = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FORE_A_LIFTOFF = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FORE_B_CONTACT = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_FORE_B_LIFTOFF = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_HEEL_CONTACT  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_HEEL_LIFTOFF  = 3'd7;

  localparam int               RESET_TH      = 256;
  localparam logic [GAP_W-1:0] RESET_GAP     = 16'd0;
  localparam logic             RESET_HEEL_EN = 1'b1;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_CONTACT  = 2'd1,
    EV_FOOT_OFF = 2'd2
  } gaitd_event_t;

  // threshold compare results for one tick
  typedef struct packed {
    logic a_contact;
    logic a_lift;
    logic b_contact;
    logic b_lift;
    logic h_contact;
    logic h_lift;
    logic heel_off_en;
  } gaitd_cmp_t;

endpackage

`default_nettype wire

// File: rtl/gaitd_thresh.sv
`default_nettype none

module gaitd_thresh #(
  parameter int FORCE_WIDTH = 16
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        wr_en,
  input  logic [gaitd_pkg::REG_IDX_W-1:0]             wr_index,
  input  logic [((FORCE_WIDTH > 16) ? FORCE_WIDTH : 16)-1:0] wr_data,
  input  logic [gaitd_pkg::FORCE_IN_W-1:0]            fore_a,
  input  logic [gaitd_pkg::FORCE_IN_W-1:0]            fore_b,
  input  logic [gaitd_pkg::FORCE_IN_W-1:0]            heel,
  output gaitd_pkg::gaitd_cmp_t                       cmp,
  output logic [gaitd_pkg::GAP_W-1:0]                 swing_gap
);
  import gaitd_pkg::*;

  localparam int CMPW = ((FORCE_WIDTH > FORCE_IN_W) ? FORCE_WIDTH : FORCE_IN_W) + 1;
  localparam logic signed [FORCE_WIDTH-1:0] TH_RST = FORCE_WIDTH'(RESET_TH);

  logic [GAP_W-1:0]              gap_r;
  logic                          heel_en_r;
  logic signed [FORCE_WIDTH-1:0] a_con_r, a_lift_r, b_con_r, b_lift_r, h_con_r, h_lift_r;
  logic signed [FORCE_WIDTH-1:0] wr_th;

  assign wr_th = wr_data[FORCE_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r     <= RESET_GAP;
      heel_en_r <= RESET_HEEL_EN;
      a_con_r   <= TH_RST;
      a_lift_r  <= TH_RST;
      b_con_r   <= TH_RST;
      b_lift_r  <= TH_RST;
      h_con_r   <= TH_RST;
      h_lift_r  <= TH_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_SWING_GAP:      gap_r     <= wr_data[GAP_W-1:0];
        REG_HEEL_OFF_EN:    heel_en_r <= wr_data[0];
        REG_FORE_A_CONTACT: a_con_r   <= wr_th;
        REG_FORE_A_LIFTOFF: a_lift_r  <= wr_th;
        REG_FORE_B_CONTACT: b_con_r   <= wr_th;
        REG_FORE_B_LIFTOFF: b_lift_r  <= wr_th;
        REG_HEEL_CONTACT:   h_con_r   <= wr_th;
        REG_HEEL_LIFTOFF:   h_lift_r  <= wr_th;
        default: ;
      endcase
    end
  end

  // force at or above threshold; force is unsigned, threshold two's complement
  function automatic logic at_or_above(input logic [FORCE_IN_W-1:0] f,
                                       input logic signed [FORCE_WIDTH-1:0] th);
    logic signed [CMPW-1:0] f_ext;
    logic signed [CMPW-1:0] th_ext;
    f_ext  = signed'(CMPW'(f));
    th_ext = CMPW'(th);
    return f_ext >= th_ext;
  endfunction

  always_comb begin
    cmp.a_contact   = at_or_above(fore_a, a_con_r);
    cmp.a_lift      = !at_or_above(fore_a, a_lift_r);
    cmp.b_contact   = at_or_above(fore_b, b_con_r);
    cmp.b_lift      = !at_or_above(fore_b, b_lift_r);
    cmp.h_contact   = at_or_above(heel, h_con_r);
    cmp.h_lift      = !at_or_above(heel, h_lift_r);
    cmp.heel_off_en = heel_en_r;
  end

  assign swing_gap = gap_r;

endmodule

`default_nettype wire

// File: rtl/gaitd_fsm.sv
`default_nettype none

module gaitd_fsm #(
  parameter int TICK_COUNT_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          advance,
  input  gaitd_pkg::gaitd_cmp_t         cmp,
  input  logic [gaitd_pkg::GAP_W-1:0]   swing_gap,
  output gaitd_pkg::gaitd_event_t       event_nxt,
  output logic                          swing_nxt
);
  import gaitd_pkg::*;

  localparam int GCW = (TICK_COUNT_WIDTH > GAP_W) ? TICK_COUNT_WIDTH : GAP_W;

  logic                        swing_r, toe_r;
  logic                        toe_nxt;
  logic [TICK_COUNT_WIDTH-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic                        gap_met;

  // saturating increment, then compare against the gap
  assign cnt_inc = (&cnt_r) ? cnt_r : cnt_r + 1'b1;
  assign gap_met = GCW'(cnt_inc) >= GCW'(swing_gap);

  always_comb begin
    swing_nxt = swing_r;
    toe_nxt   = toe_r;
    cnt_nxt   = cnt_r;
    if (swing_r) begin
      cnt_nxt = cnt_inc;
      if (gap_met && cmp.h_contact) swing_nxt = 1'b0;
    end else if (toe_r) begin
      if (cmp.a_contact || cmp.b_contact) toe_nxt = 1'b0;
    end else if (cmp.a_lift && cmp.b_lift && (!cmp.heel_off_en || cmp.h_lift)) begin
      swing_nxt = 1'b1;
      toe_nxt   = 1'b1;
      cnt_nxt   = '0;
    end
  end

  always_comb begin
    if (swing_nxt == swing_r) event_nxt = EV_NONE;
    else if (swing_nxt)       event_nxt = EV_FOOT_OFF;
    else                      event_nxt = EV_CONTACT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swing_r <= 1'b0;
      toe_r   <= 1'b0;
      cnt_r   <= '0;
    end else if (advance) begin
      swing_r <= swing_nxt;
      toe_r   <= toe_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/gait_event_detector_top.sv
// Gait event detector, one instance per foot.
//
// Input channel (in_valid / in_stall): one beat per detector tick, carrying
// the calibrated forefoot A, forefoot B and heel forces. A beat is taken at a
// rising edge with in_valid high and in_stall low.
// Output channel (out_valid / out_stall): exactly one beat per input beat,
// with the gait event (none, initial contact, foot off) and the swing state
// after that tick, in input order.
// Configuration channel (cfg_valid / cfg_ready): register index and data;
// cfg_ready is always high. Write only while no tick is in flight.
//
// Throughput: one tick per cycle while the receiver does not stall. A taken
// beat is held in the input register, which feeds the threshold compares
// and the stance/swing update, which land in the output register.
// When the receiver stalls, the output beat holds and the input register
// fills; in_stall then rises and follows out_stall until the output drains.
// Reset (rst_n low, synchronous) empties both stages, returns to stance with
// toe-off clear and the tick counter at zero, and restores register defaults.
`default_nettype none

module gait_event_detector_top #(
  parameter int TICK_COUNT_WIDTH = 16,
  parameter int FORCE_WIDTH      = 16
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_valid,
  output logic                                        in_stall,
  input  logic [14:0]                                 in_fore_a_force,
  input  logic [14:0]                                 in_fore_b_force,
  input  logic [14:0]                                 in_heel_force,
  output logic                                        out_valid,
  input  logic                                        out_stall,
  output logic [1:0]                                  out_gait_event,
  output logic                                        out_in_swing,
  input  logic                                        cfg_valid,
  output logic                                        cfg_ready,
  input  logic [gaitd_pkg::REG_IDX_W-1:0]             cfg_index,
  input  logic [((FORCE_WIDTH > 16) ? FORCE_WIDTH : 16)-1:0] cfg_data
);
  import gaitd_pkg::*;

  logic                  s1_valid_r;
  logic [FORCE_IN_W-1:0] s1_fa_r, s1_fb_r, s1_fh_r;
  logic                  out_valid_r;
  gaitd_event_t          event_r, event_nxt;
  logic                  swing_r, swing_nxt;
  logic                  out_adv, in_take;
  gaitd_cmp_t            cmp;
  logic [GAP_W-1:0]      swing_gap;

  // output register moves when empty or being taken
  assign out_adv  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !out_adv;
  assign in_take  = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_fa_r <= in_fore_a_force;
      s1_fb_r <= in_fore_b_force;
      s1_fh_r <= in_heel_force;
    end
  end

  gaitd_thresh #(
    .FORCE_WIDTH (FORCE_WIDTH)
  ) u_thresh (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (cfg_valid && cfg_ready),
    .wr_index  (cfg_index),
    .wr_data   (cfg_data),
    .fore_a    (s1_fa_r),
    .fore_b    (s1_fb_r),
    .heel      (s1_fh_r),
    .cmp       (cmp),
    .swing_gap (swing_gap)
  );

  // state advances once per tick, as the tick moves into the output register
  gaitd_fsm #(
    .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
  ) u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (s1_valid_r && out_adv),
    .cmp       (cmp),
    .swing_gap (swing_gap),
    .event_nxt (event_nxt),
    .swing_nxt (swing_nxt)
  );

  // output register; hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      event_r <= event_nxt;
      swing_r <= swing_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_gait_event = event_r;
  assign out_in_swing   = swing_r;

endmodule

`default_nettype wire

// File: rtl/gaitd_checker.sv
`default_nettype none

`include "gait_event_detector_top_assert.svh"

module gaitd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_gait_event,
  input logic       out_in_swing
);
  import gaitd_pkg::*;

  logic seen_r;
  logic last_swing_r;

  // track swing state of the last delivered beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r       <= 1'b0;
      last_swing_r <= 1'b0;
    end else if (out_valid && !out_stall) begin
      seen_r       <= 1'b1;
      last_swing_r <= out_in_swing;
    end
  end

  `GED_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_gait_event) && $stable(out_in_swing))
  `GED_ASSERT_IMP(a_event_matches_swing, out_valid && (out_gait_event != EV_NONE), (out_gait_event == EV_FOOT_OFF) == out_in_swing)
  `GED_ASSERT_IMP(a_event_marks_change, out_valid && seen_r, (out_gait_event == EV_NONE) == (out_in_swing == last_swing_r))
  `GED_ASSERT_RST(a_reset_empties, !rst_n, !out_valid && !in_stall)

endmodule

bind gait_event_detector_top gaitd_checker u_gaitd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_gait_event (out_gait_event),
  .out_in_swing   (out_in_swing)
);

`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 100ps

import gaitd_pkg::*;

// Detector register set, as loaded through the configuration port
typedef struct {
  logic [15:0]        gap;
  logic               heel_en;
  logic signed [15:0] a_con;
  logic signed [15:0] a_lift;
  logic signed [15:0] b_con;
  logic signed [15:0] b_lift;
  logic signed [15:0] h_con;
  logic signed [15:0] h_lift;
} gait_cfg_t;

// One output beat: event code and swing state after the tick
typedef struct {
  gaitd_event_t ev;
  logic         swing;
} tick_result_t;

function automatic gait_cfg_t default_cfg();
  gait_cfg_t c;
  c.gap     = RESET_GAP;
  c.heel_en = RESET_HEEL_EN;
  c.a_con   = 16'(RESET_TH);
  c.a_lift  = 16'(RESET_TH);
  c.b_con   = 16'(RESET_TH);
  c.b_lift  = 16'(RESET_TH);
  c.h_con   = 16'(RESET_TH);
  c.h_lift  = 16'(RESET_TH);
  return c;
endfunction

class gait_scoreboard;
  gait_cfg_t    regs;
  bit           swing;
  bit           toe_off;
  logic [15:0]  swing_ticks;
  tick_result_t due[$];
  int unsigned  errors;

  function new();
    regs        = default_cfg();
    swing       = 1'b0;
    toe_off     = 1'b0;
    swing_ticks = '0;
    errors      = 0;
  endfunction

  function void write_reg(logic [REG_IDX_W-1:0] idx, logic [15:0] data);
    case (idx)
      REG_SWING_GAP:      regs.gap     = data;
      REG_HEEL_OFF_EN:    regs.heel_en = data[0];
      REG_FORE_A_CONTACT: regs.a_con   = data;
      REG_FORE_A_LIFTOFF: regs.a_lift  = data;
      REG_FORE_B_CONTACT: regs.b_con   = data;
      REG_FORE_B_LIFTOFF: regs.b_lift  = data;
      REG_HEEL_CONTACT:   regs.h_con   = data;
      REG_HEEL_LIFTOFF:   regs.h_lift  = data;
      default: ;
    endcase
  endfunction

  // forces are never negative, so widen with a zero sign bit before comparing
  static function bit at_or_above(logic [14:0] f, logic signed [15:0] th);
    return $signed({1'b0, f}) >= th;
  endfunction

  function void note_tick(logic [14:0] fa, logic [14:0] fb, logic [14:0] fh);
    bit           was_swing;
    tick_result_t r;
    was_swing = swing;
    if (swing) begin
      // count first (saturating), then test against the gap
      if (swing_ticks != 16'hFFFF) swing_ticks = swing_ticks + 16'd1;
      if (swing_ticks >= regs.gap && at_or_above(fh, regs.h_con)) swing = 1'b0;
    end else if (toe_off) begin
      if (at_or_above(fa, regs.a_con) || at_or_above(fb, regs.b_con)) toe_off = 1'b0;
    end else begin
      if (!at_or_above(fa, regs.a_lift) && !at_or_above(fb, regs.b_lift) &&
          (!regs.heel_en || !at_or_above(fh, regs.h_lift))) begin
        swing       = 1'b1;
        toe_off     = 1'b1;
        swing_ticks = '0;
      end
    end
    if (swing == was_swing) r.ev = EV_NONE;
    else r.ev = swing ? EV_FOOT_OFF : EV_CONTACT;
    r.swing = swing;
    due = {due, r};
  endfunction

  task report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task check_result(logic [1:0] ev, logic sw);
    tick_result_t want;
    if (due.size() == 0) begin
      report($sformatf("output beat with nothing pending, event %0d swing %0b", ev, sw));
      return;
    end
    want = due.pop_front();
    if (ev !== want.ev)
      report($sformatf("gait_event %0d, want %s", ev, want.ev.name()));
    if (sw !== want.swing)
      report($sformatf("in_swing %0b, want %0b", sw, want.swing));
  endtask
endclass

module tb_top;

  localparam int IDLE_PCT     = 9;
  localparam int PHASES       = 6;
  localparam int PHASE_TICKS  = 210;
  localparam int HOLD_AT      = 400;      // output beats before the long hold-off
  localparam int HOLD_CYCLES  = 150;
  localparam int CYCLE_LIMIT  = 50000;
  localparam int LONG_SWING   = 200;      // swing ticks under the largest gap

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_stall;
  logic [14:0] in_fore_a_force = '0;
  logic [14:0] in_fore_b_force = '0;
  logic [14:0] in_heel_force   = '0;
  logic        out_valid;
  logic        out_stall       = 1'b0;
  logic [1:0]  out_gait_event;
  logic        out_in_swing;
  logic        cfg_valid       = 1'b0;
  logic        cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data        = '0;

  gait_scoreboard sb = new();
  gait_cfg_t      cur;           // settings the stimulus aims at
  bit             calm = 1'b1;   // suppress random idling on both sides
  int unsigned    sent;
  int unsigned    cycle_count = 0;
  int unsigned    rx_beats = 0;
  int unsigned    hold_left = 0;
  bit             hold_done = 1'b0;

  gait_event_detector_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_fore_a_force (in_fore_a_force),
    .in_fore_b_force (in_fore_b_force),
    .in_heel_force   (in_heel_force),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_gait_event  (out_gait_event),
    .out_in_swing    (out_in_swing),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  // Watchdog: abandon the run if it hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Observe all three channels on the edge itself; inputs change only after
  // the edge, so the values seen here are the ones the block sampled.
  // Check the output before noting the input: a beat leaving this edge can
  // never belong to one arriving on it.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_gait_event, out_in_swing);
      if (in_valid && !in_stall)
        sb.note_tick(in_fore_a_force, in_fore_b_force, in_heel_force);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here so that the
  // sender keeps offering beats and the block backs up into in_stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) rx_beats++;
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && rx_beats >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Mostly uniform, with the field extremes turning up often.
  function automatic logic [14:0] rand15();
    case ($urandom_range(7))
      0:       return 15'd0;
      1:       return 15'h7FFF;
      default: return 15'($urandom_range(32767));
    endcase
  endfunction

  // Force strictly under a threshold, often one below it; any value if none exists.
  function automatic logic [14:0] force_below(logic signed [15:0] th);
    int lim;
    lim = th;
    if (lim <= 0) return rand15();
    if ($urandom_range(3) == 0) return 15'(lim - 1);
    return 15'($urandom_range(lim - 1));
  endfunction

  // Force at or above a threshold, often exactly on it.
  function automatic logic [14:0] force_at_least(logic signed [15:0] th);
    int lo;
    lo = (th < 0) ? 0 : int'(th);
    if ($urandom_range(3) == 0) return 15'(lo);
    return 15'($urandom_range(32767, lo));
  endfunction

  function automatic logic signed [15:0] rand_th(int unsigned span);
    return 16'($urandom_range(span));
  endfunction

  function automatic gait_cfg_t phase_cfg(int p);
    gait_cfg_t c;
    c.gap     = 16'($urandom_range(10));
    c.heel_en = 1'b1;
    c.a_con   = rand_th(4000);
    c.a_lift  = rand_th(4000);
    c.b_con   = rand_th(4000);
    c.b_lift  = rand_th(4000);
    c.h_con   = rand_th(4000);
    c.h_lift  = rand_th(4000);
    case (p)
      0: begin
        // heel ignored for foot-off, contact allowed on the first swing tick
        c.gap     = 16'd0;
        c.heel_en = 1'b0;
      end
      2: begin
        // lifted except at full scale, always in contact
        c.gap    = 16'd2;
        c.a_con  = 16'sh8000;
        c.b_con  = 16'sh8000;
        c.h_con  = 16'sh8000;
        c.a_lift = 16'sh7FFF;
        c.b_lift = 16'sh7FFF;
        c.h_lift = 16'sh7FFF;
      end
      3: begin
        // never lifted, contact only at full scale
        c.gap    = 16'd0;
        c.a_con  = 16'sh7FFF;
        c.b_con  = 16'sh7FFF;
        c.h_con  = 16'sh7FFF;
        c.a_lift = 16'sh8000;
        c.b_lift = 16'sh8000;
        c.h_lift = 16'sh8000;
      end
      4: begin
        // whole threshold range, signs included
        c.gap     = 16'($urandom_range(20));
        c.heel_en = 1'($urandom_range(1));
        c.a_con   = 16'($urandom);
        c.a_lift  = 16'($urandom);
        c.b_con   = 16'($urandom);
        c.b_lift  = 16'($urandom);
        c.h_con   = 16'($urandom);
        c.h_lift  = 16'($urandom);
      end
      default: ;
    endcase
    return c;
  endfunction

  // Offer one tick; idle first at random, return on the edge that takes it.
  task automatic send_tick(logic [14:0] fa, logic [14:0] fb, logic [14:0] fh);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_fore_a_force <= fa;
    in_fore_b_force <= fb;
    in_heel_force   <= fh;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // Drop valid and wait until every pending beat has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Hold valid across back-to-back writes; drop it once the set is loaded.
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_cfg(gait_cfg_t c);
    cur = c;
    write_reg(REG_SWING_GAP, c.gap);
    write_reg(REG_HEEL_OFF_EN, {15'd0, c.heel_en});
    write_reg(REG_FORE_A_CONTACT, c.a_con);
    write_reg(REG_FORE_A_LIFTOFF, c.a_lift);
    write_reg(REG_FORE_B_CONTACT, c.b_con);
    write_reg(REG_FORE_B_LIFTOFF, c.b_lift);
    write_reg(REG_HEEL_CONTACT, c.h_con);
    write_reg(REG_HEEL_LIFTOFF, c.h_lift);
    cfg_valid <= 1'b0;
  endtask

  // One step of walking: load the forefoot, lift off, swing, strike the heel.
  task automatic send_stride();
    int swing_len;
    repeat ($urandom_range(3, 1)) begin
      if ($urandom_range(1))
        send_tick(force_at_least(cur.a_con), rand15(), force_at_least(cur.h_con));
      else
        send_tick(rand15(), force_at_least(cur.b_con), force_at_least(cur.h_con));
    end
    send_tick(force_below(cur.a_lift), force_below(cur.b_lift), force_below(cur.h_lift));
    // a huge gap would never close; keep those swings short and let them run on
    swing_len = (cur.gap > 60) ? int'($urandom_range(8, 1))
                               : int'(cur.gap) + int'($urandom_range(2));
    for (int i = 1; i < swing_len; i++) begin
      // the odd early strike, which the gap should mask
      if ($urandom_range(9) == 0) send_tick(rand15(), rand15(), force_at_least(cur.h_con));
      else send_tick(rand15(), rand15(), force_below(cur.h_con));
    end
    send_tick(rand15(), rand15(), force_at_least(cur.h_con));
  endtask

  initial begin
    gait_cfg_t c;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values, thresholds at 256 and a zero gap: walk the edges of each
    // compare, contact on the first swing tick, and both forefoot paths that
    // clear toe-off. Alternating bit patterns toggle every force bit.
    send_tick(15'd0,     15'd0,     15'd0);      // foot-off
    send_tick(15'h7FFF,  15'h7FFF,  15'h7FFF);   // contact at once
    send_tick(15'd0,     15'd0,     15'd0);      // toe-off still set, no lift
    send_tick(15'd255,   15'd255,   15'd0);      // just short of contact
    send_tick(15'd256,   15'd0,     15'd0);      // A on its threshold clears toe-off
    send_tick(15'd255,   15'd255,   15'd255);    // all just under: foot-off
    send_tick(15'd0,     15'd0,     15'd255);    // heel just light
    send_tick(15'h7FFF,  15'h7FFF,  15'd255);    // forefoot ignored in swing
    send_tick(15'd0,     15'd0,     15'd256);    // heel on threshold: contact
    send_tick(15'd0,     15'd256,   15'd0);      // B clears toe-off
    send_tick(15'd255,   15'd255,   15'd256);    // heel not off
    send_tick(15'd256,   15'd255,   15'd0);      // A not off
    send_tick(15'd255,   15'd256,   15'd0);      // B not off
    send_tick(15'd0,     15'd0,     15'd0);      // foot-off
    send_tick(15'h5555,  15'h2AAA,  15'h5555);   // contact
    send_tick(15'h2AAA,  15'h5555,  15'h2AAA);   // clears toe-off
    send_tick(15'h7FFF,  15'd0,     15'd0);
    send_tick(15'd0,     15'h7FFF,  15'd0);
    send_tick(15'd0,     15'd0,     15'h7FFF);
    drain();

    // Largest gap: swing cannot close within this stretch, however hard the
    // heel strikes. The next phase's small gap then ends it.
    c = default_cfg();
    c.gap = 16'hFFFF;
    load_cfg(c);
    send_tick(15'd0, 15'd0, 15'd0);
    for (int i = 1; i <= LONG_SWING; i++)
      send_tick(rand15(), rand15(), rand15());
    drain();

    // Random walking under a spread of settings; the first phase runs without
    // idling, the rest idle at random. Leave a fifth of the bursts as noise.
    for (int p = 0; p < PHASES; p++) begin
      c = phase_cfg(p);
      calm = (p == 0);
      load_cfg(c);
      sent = 0;
      while (sent < PHASE_TICKS) begin
        if ($urandom_range(99) < 80) send_stride();
        else repeat ($urandom_range(3, 1)) send_tick(rand15(), rand15(), rand15());
      end
      drain();
    end

    if (sb.due.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.due.size()));
    if (sb.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/gaitd_pkg.sv
rtl/gaitd_thresh.sv
rtl/gaitd_fsm.sv
rtl/gait_event_detector_top.sv
rtl/gaitd_checker.sv
verif/tb_top.sv
